FILE: design/hbw_pkg.sv
// Shared types and constants of the heartbeat watchdog.
// Depends on nothing; every other file of the block imports it.
package hbw_pkg;

    localparam int TIME_W      = 63;
    localparam int LIMIT_W     = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 63;
    localparam int SRC_IDX_W   = 2;
    localparam int STATE_W     = 2;
    localparam int MAX_SOURCES = 4;
    localparam int DEF_SOURCES = 4;

    localparam logic [LIMIT_W-1:0] DEF_TIMEOUT = LIMIT_W'(100000000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT     = 3'd6;

    // command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_EVAL   = 1'b1;

    // source and overall state codes
    localparam logic [STATE_W-1:0] ST_WAITING = 2'd0;
    localparam logic [STATE_W-1:0] ST_HEALTHY = 2'd1;
    localparam logic [STATE_W-1:0] ST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [SRC_IDX_W-1:0] source_index;
        logic [TIME_W-1:0]    now_time;
    } in_item_t;

    typedef struct packed {
        logic [SRC_IDX_W-1:0] result_source;
        logic [STATE_W-1:0]   source_state;
        logic                 heard_once;
        logic [TIME_W-1:0]    last_seen_time;
        logic                 is_critical;
        logic [STATE_W-1:0]   group_state;
        logic                 critical_all_healthy;
        logic                 last_of_run;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic                 upd;
        logic                 load_now;
        logic                 eval;
        logic                 emit;
        logic                 last;
        logic [SRC_IDX_W-1:0] idx;
    } hbw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } hbw_stat_t;

endpackage

FILE: design/hbw_ctrl.sv
// Sequencer of the heartbeat watchdog: idle, per-source evaluate pass, emit pass.
// Depends on hbw_pkg.
module hbw_ctrl #(
    parameter int SOURCES = hbw_pkg::DEF_SOURCES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_command,
    output logic              in_stall,
    input  hbw_pkg::hbw_stat_t stat,
    output hbw_pkg::hbw_cmd_t  cmd
);
    import hbw_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [SRC_IDX_W-1:0] LAST_IDX = SRC_IDX_W'(SOURCES - 1);

    logic [1:0]           state_reg, state_next;
    logic [SRC_IDX_W-1:0] cnt_reg, cnt_next;
    logic                 is_last;

    assign is_last  = (cnt_reg == LAST_IDX);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.idx      = cnt_reg;
        cmd.last     = is_last;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_UPDATE)
                    begin
                        cmd.upd = 1'b1;
                    end
                    else
                    begin
                        cmd.load_now = 1'b1;
                        cnt_next     = '0;
                        state_next   = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (is_last)
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (is_last)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: design/hbw_dp.sv
// Datapath of the heartbeat watchdog: configuration, last-seen store, the shared
// elapsed-time compare unit, per-source state and the output register. Depends on hbw_pkg.
module hbw_dp #(
    parameter int SOURCES = hbw_pkg::DEF_SOURCES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hbw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hbw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  hbw_pkg::in_item_t                 in_item,
    input  hbw_pkg::hbw_cmd_t                 cmd,
    output hbw_pkg::hbw_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_stall,
    output hbw_pkg::out_item_t                out_item
);
    import hbw_pkg::*;

    localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    logic [LIMIT_W-1:0]   grace_reg;
    logic [TIME_W-1:0]    start_reg;
    logic [LIMIT_W-1:0]   timeout_reg [SOURCES];
    logic [SOURCES-1:0]   crit_reg;

    logic [TIME_W-1:0]    store_reg [SOURCES];
    logic [SOURCES-1:0]   heard_reg;
    logic [STATE_W-1:0]   st_reg [SOURCES];

    logic [TIME_W-1:0]    now_reg;
    logic                 any_to_reg;
    logic                 any_wait_reg;
    logic                 all_ok_reg;

    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic [SRC_W-1:0]     idx;
    logic [SRC_W-1:0]     upd_idx;
    logic                 upd_ok;
    logic [CFG_IDX_W-1:0] cfg_off;
    logic [SRC_W-1:0]     cfg_src;
    logic                 cfg_to_hit;

    logic                 heard;
    logic [TIME_W-1:0]    then_v;
    logic [LIMIT_W-1:0]   limit_v;
    logic [TIME_W:0]      diff;
    logic [TIME_W-1:0]    elapsed;
    logic                 expired;
    logic [STATE_W-1:0]   st_new;
    logic                 bad_crit;
    logic [STATE_W-1:0]   overall;

    assign idx     = cmd.idx[SRC_W-1:0];
    assign upd_idx = in_item.source_index[SRC_W-1:0];
    assign upd_ok  = (3'(in_item.source_index) < 3'(SOURCES));

    assign cfg_off    = cfg_index - CFG_TIMEOUT0;
    assign cfg_src    = cfg_off[SRC_W-1:0];
    assign cfg_to_hit = (cfg_index >= CFG_TIMEOUT0)
                     && (4'(cfg_index) < 4'(CFG_TIMEOUT0) + 4'(SOURCES));

    // one subtract and compare per cycle, shared by all sources
    assign heard   = heard_reg[idx];
    assign then_v  = heard ? store_reg[idx] : start_reg;
    assign limit_v = heard ? timeout_reg[idx] : grace_reg;
    assign diff    = {1'b0, now_reg} - {1'b0, then_v};
    assign elapsed = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    assign expired = (elapsed >= {{(TIME_W-LIMIT_W){1'b0}}, limit_v});
    assign st_new  = expired ? ST_TIMEOUT : (heard ? ST_HEALTHY : ST_WAITING);
    assign bad_crit = crit_reg[idx] && (st_new != ST_HEALTHY);

    assign overall = any_to_reg ? ST_TIMEOUT : (any_wait_reg ? ST_WAITING : ST_HEALTHY);

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg <= '0;
            start_reg <= '0;
            crit_reg  <= '1;
            for (int i = 0; i < SOURCES; i++)
            begin
                timeout_reg[i] <= DEF_TIMEOUT;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_GRACE)
            begin
                grace_reg <= cfg_data[LIMIT_W-1:0];
            end
            if (cfg_index == CFG_START)
            begin
                start_reg <= cfg_data[TIME_W-1:0];
            end
            if (cfg_to_hit)
            begin
                timeout_reg[cfg_src] <= cfg_data[LIMIT_W-1:0];
            end
            if (cfg_index == CFG_CRIT)
            begin
                crit_reg <= cfg_data[SOURCES-1:0];
            end
        end
    end

    // last-seen store and heard flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heard_reg <= '0;
            for (int i = 0; i < SOURCES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd.upd && upd_ok)
        begin
            store_reg[upd_idx] <= in_item.now_time;
            heard_reg[upd_idx] <= 1'b1;
        end
    end

    // evaluate pass: per-source state and the critical summary
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_to_reg   <= 1'b0;
            any_wait_reg <= 1'b0;
            all_ok_reg   <= 1'b1;
        end
        else if (cmd.load_now)
        begin
            any_to_reg   <= 1'b0;
            any_wait_reg <= 1'b0;
            all_ok_reg   <= 1'b1;
        end
        else if (cmd.eval && bad_crit)
        begin
            all_ok_reg <= 1'b0;
            if (st_new == ST_TIMEOUT)
            begin
                any_to_reg <= 1'b1;
            end
            if (st_new == ST_WAITING)
            begin
                any_wait_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_now)
        begin
            now_reg <= in_item.now_time;
        end
        if (cmd.eval)
        begin
            st_reg[idx] <= st_new;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.result_source        <= cmd.idx;
            out_reg.source_state         <= st_reg[idx];
            out_reg.heard_once           <= heard_reg[idx];
            out_reg.last_seen_time       <= store_reg[idx];
            out_reg.is_critical          <= crit_reg[idx];
            out_reg.group_state          <= overall;
            out_reg.critical_all_healthy <= all_ok_reg;
            out_reg.last_of_run          <= cmd.last;
        end
    end

endmodule

FILE: design/multi_source_heartbeat_watchdog.sv
// Top level of the heartbeat watchdog: controller plus datapath.
// Depends on hbw_pkg, hbw_ctrl and hbw_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes one item per command.
//   An update item (command 0) stores now_time as the last-seen time of the
//   named source and marks it heard; it yields no result.
//   Updates to a source index at or above SOURCES are dropped.
//   An evaluate item (command 1) yields SOURCES result items on the output
//   channel (out_valid / out_stall / out_item), in source order, with
//   last_of_run set on the final one.
//   An evaluate runs the sources through the shared elapsed-time
//   subtract/compare unit (one source a cycle), then loads the results
//   into the output register, one after another, in source order.
//   The block works on one item at a time; in_stall is high while it does.
//   When the receiver stalls, the output register holds its result and the
//   emit pass waits; a finished last result may sit in the output register
//   while the next item is accepted.
//   Configuration (cfg_we / cfg_index / cfg_data) is to be written only
//   while idle; the block itself does not enforce this. Reset clears the
//   heard flags and last-seen store, and returns the configuration
//   registers to their defaults (grace 0, start 0, timeouts 100 ms, all
//   critical).
module multi_source_heartbeat_watchdog #(
    parameter int SOURCES = hbw_pkg::DEF_SOURCES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hbw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  hbw_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output hbw_pkg::out_item_t             out_item
);
    import hbw_pkg::*;

    hbw_cmd_t  cmd;
    hbw_stat_t stat;

    // sequencer: idle, evaluate pass, emit pass
    hbw_ctrl #(
        .SOURCES (SOURCES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_item.command),
        .in_stall   (in_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // configuration, store, compare unit and output register
    hbw_dp #(
        .SOURCES (SOURCES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
